FILE: rtl/core/entity_slot_allocator_defines.svh
// ----------------------------------------------------------------------------
// entity_slot_allocator_defines.svh
// assertion macros used by the checker of the slot allocator
// ----------------------------------------------------------------------------
`ifndef ENTITY_SLOT_ALLOCATOR_DEFINES_SVH
`define ENTITY_SLOT_ALLOCATOR_DEFINES_SVH

// concurrent check on clk, switched off while reset is held
`define ESA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// concurrent check on clk that also holds during reset
`define ESA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: rtl/core/esa_pkg.sv
// ----------------------------------------------------------------------------
// esa_pkg
// field widths and operation codes of the entity slot allocator
// ----------------------------------------------------------------------------
package esa_pkg;

    // command field widths
    localparam int OP_W    = 3;
    localparam int SLOT_W  = 6;
    localparam int SCENE_W = 4;
    localparam int COMP_W  = 3;
    localparam int MAXC_W  = 7;

    // response field widths
    localparam int MASK_W  = 7;
    localparam int COUNT_W = 7;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 3'd0,
        OP_DESTROY = 3'd1,
        OP_ATTACH  = 3'd2,
        OP_QUERY   = 3'd3,
        OP_LIST    = 3'd4
    } op_t;

endpackage

FILE: rtl/core/esa_if.sv
// ----------------------------------------------------------------------------
// esa_if
// valid/ready channels of the slot allocator: command and response
// ----------------------------------------------------------------------------

// command channel
interface esa_cmd_if;
    import esa_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SLOT_W-1:0] slot;
    logic [SCENE_W-1:0] scene;
    logic [COMP_W-1:0] component;
    logic [MAXC_W-1:0] max_count;

    modport source (
        output valid, operation, slot, scene, component, max_count,
        input  ready
    );
    modport sink (
        input  valid, operation, slot, scene, component, max_count,
        output ready
    );
endinterface

// response channel
interface esa_rsp_if;
    import esa_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [SLOT_W-1:0]  slot_id;
    logic               is_alive;
    logic [MASK_W-1:0]  comp_mask;
    logic [SCENE_W-1:0] scene_tag;
    logic [COUNT_W-1:0] live_count;
    logic               last;

    modport source (
        output valid, found, slot_id, is_alive, comp_mask, scene_tag, live_count, last,
        input  ready
    );
    modport sink (
        input  valid, found, slot_id, is_alive, comp_mask, scene_tag, live_count, last,
        output ready
    );
endinterface

FILE: rtl/core/entity_slot_allocator.sv
// ----------------------------------------------------------------------------
// entity_slot_allocator
// fixed pool of entity slots with alive bit, component mask and scene tag
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+-----------------------------------------------
//  cmd     | in  | valid/ready  | operation, slot, scene, component, max_count
//  rsp     | out | valid/ready  | found, slot_id, is_alive, comp_mask,
//          |     |              | scene_tag, live_count, last
//
//  destroy, attach and query pass through a ram read (ST_FETCH) and an execute (ST_EXEC), then idle.
//  create searches for the lowest free slot: one slot probe unit steps
//  through the alive bits one slot per cycle.
//  listing steps over dead slots in ST_LIST_RD alone;
//  every live slot costs a read of the single ram read port and a compare.
//  reset clears the alive bits and the live counter at once, no sweep.
//  a held response stalls the sequencer only when it has a new one to emit.
//
module entity_slot_allocator #(
    parameter int SLOTS           = 64,
    parameter int COMPONENT_KINDS = 7,
    parameter int SCENE_BITS      = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    esa_cmd_if.sink   cmd,
    esa_rsp_if.source rsp
);
    import esa_pkg::*;

    localparam int IW  = $clog2(SLOTS);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int DW  = COMPONENT_KINDS + SCENE_BITS;
    localparam int MWW = (COMPONENT_KINDS > MASK_W) ? COMPONENT_KINDS : MASK_W;
    localparam int SWW = (SCENE_BITS > SCENE_W) ? SCENE_BITS : SCENE_W;
    localparam logic [IW-1:0]     LAST_IDX  = IW'(SLOTS - 1);
    localparam logic [CW-1:0]     SLOTS_C   = CW'(SLOTS);
    localparam logic [SLOT_W:0]   SLOTS_EXT = (SLOT_W + 1)'(SLOTS);
    localparam logic [MAXC_W-1:0] MAXC_LIM  = MAXC_W'(SLOTS);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_FREE     = 7'b0000010,
        ST_FETCH    = 7'b0000100,
        ST_EXEC     = 7'b0001000,
        ST_LIST_RD  = 7'b0010000,
        ST_LIST_CHK = 7'b0100000,
        ST_LIST_END = 7'b1000000
    } state_t;

    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  slot_id;
        logic               is_alive;
        logic [MASK_W-1:0]  comp_mask;
        logic [SCENE_W-1:0] scene_tag;
        logic [COUNT_W-1:0] live_count;
        logic               last;
    } rsp_t;

    // resize stored fields to the response widths
    function automatic logic [MASK_W-1:0] mask_out(input logic [COMPONENT_KINDS-1:0] m);
        logic [MWW-1:0] w;
        w = MWW'(m);
        return w[MASK_W-1:0];
    endfunction

    function automatic logic [SCENE_W-1:0] scene_out(input logic [SCENE_BITS-1:0] s);
        logic [SWW-1:0] w;
        w = SWW'(s);
        return w[SCENE_W-1:0];
    endfunction

    // control state
    state_t                    state_reg, state_next;
    logic [SLOTS-1:0]          alive_reg, alive_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [IW-1:0]             idx_reg, idx_next;
    logic [CW-1:0]             taken_reg, taken_next;
    logic                      hold_valid_reg, hold_valid_next;
    logic                      out_valid_reg, out_valid_next;

    // transaction and payload registers
    logic [OP_W-1:0]            op_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic [SCENE_BITS-1:0]      key_reg;
    logic [COMP_W-1:0]          comp_reg;
    logic [CW-1:0]              limit_reg;
    logic [IW-1:0]              hold_slot_reg, hold_slot_next;
    logic [COMPONENT_KINDS-1:0] hold_mask_reg, hold_mask_next;
    logic [SCENE_BITS-1:0]      hold_scene_reg, hold_scene_next;
    rsp_t                       out_reg;

    // ram port
    logic                       ram_we;
    logic [IW-1:0]              ram_waddr;
    logic [DW-1:0]              ram_wdata;
    logic [IW-1:0]              ram_raddr;
    logic [DW-1:0]              ram_rdata;
    logic [COMPONENT_KINDS-1:0] rd_mask;
    logic [SCENE_BITS-1:0]      rd_scene;

    // misc
    logic                       cmd_fire;
    logic                       can_emit;
    logic                       emit;
    rsp_t                       emit_data;
    logic [SWW-1:0]             scene_wide;
    logic [SCENE_BITS-1:0]      key_in;
    logic [CW-1:0]              limit_in;
    logic [IW-1:0]              slot_idx;
    logic                       slot_in_range;
    logic                       slot_alive;
    logic                       comp_ok;
    logic                       attach_ok;
    logic [COMPONENT_KINDS-1:0] comp_bit;
    logic [COMPONENT_KINDS-1:0] attach_mask;
    logic [COMPONENT_KINDS-1:0] alive_mask;
    logic [CW-1:0]              count_inc;
    logic [CW-1:0]              count_dec;
    logic [CW-1:0]              taken_inc;
    rsp_t                       free_rsp;
    rsp_t                       full_rsp;
    rsp_t                       exec_rsp;
    rsp_t                       hold_rsp;
    rsp_t                       empty_rsp;

    // slot data store: component mask over scene tag
    esa_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_esa_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_mask  = ram_rdata[DW-1:SCENE_BITS];
    assign rd_scene = ram_rdata[SCENE_BITS-1:0];

    // handshakes
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign can_emit  = !out_valid_reg || rsp.ready;

    // command decode at accept
    assign scene_wide = SWW'(cmd.scene);
    assign key_in     = scene_wide[SCENE_BITS-1:0];
    assign limit_in   = (cmd.max_count > MAXC_LIM) ? SLOTS_C : cmd.max_count[CW-1:0];

    // addressed slot
    assign slot_idx      = slot_reg[IW-1:0];
    assign slot_in_range = {1'b0, slot_reg} < SLOTS_EXT;
    assign slot_alive    = alive_reg[slot_idx];
    assign comp_ok       = int'(comp_reg) < COMPONENT_KINDS;
    assign attach_ok     = slot_alive && comp_ok;
    assign comp_bit      = COMPONENT_KINDS'(1) << comp_reg;
    assign attach_mask   = rd_mask | comp_bit;
    assign alive_mask    = slot_alive ? rd_mask : '0;

    // counter arithmetic
    assign count_inc = (count_reg < SLOTS_C) ? count_reg + CW'(1) : count_reg;
    assign count_dec = (count_reg != '0) ? count_reg - CW'(1) : count_reg;
    assign taken_inc = taken_reg + CW'(1);

    // candidate responses
    always_comb
    begin
        free_rsp            = '0;
        free_rsp.found      = 1'b1;
        free_rsp.slot_id    = SLOT_W'(idx_reg);
        free_rsp.is_alive   = 1'b1;
        free_rsp.scene_tag  = scene_out(key_reg);
        free_rsp.live_count = COUNT_W'(count_inc);
        free_rsp.last       = 1'b1;

        full_rsp            = '0;
        full_rsp.live_count = COUNT_W'(count_reg);
        full_rsp.last       = 1'b1;

        empty_rsp           = full_rsp;

        hold_rsp            = '0;
        hold_rsp.found      = 1'b1;
        hold_rsp.slot_id    = SLOT_W'(hold_slot_reg);
        hold_rsp.is_alive   = 1'b1;
        hold_rsp.comp_mask  = mask_out(hold_mask_reg);
        hold_rsp.scene_tag  = scene_out(hold_scene_reg);
        hold_rsp.live_count = COUNT_W'(count_reg);
        hold_rsp.last       = 1'b0;

        exec_rsp            = '0;
        exec_rsp.live_count = COUNT_W'(count_reg);
        exec_rsp.last       = 1'b1;
        case (op_reg)
            OP_DESTROY:
            begin
                exec_rsp.slot_id = slot_reg;
                if (slot_in_range)
                begin
                    exec_rsp.found      = 1'b1;
                    exec_rsp.live_count = COUNT_W'(count_dec);
                end
            end
            OP_ATTACH:
            begin
                exec_rsp.slot_id = slot_reg;
                if (slot_in_range)
                begin
                    exec_rsp.found     = attach_ok;
                    exec_rsp.is_alive  = slot_alive;
                    exec_rsp.comp_mask = attach_ok ? mask_out(attach_mask)
                                                   : mask_out(alive_mask);
                    exec_rsp.scene_tag = scene_out(rd_scene);
                end
            end
            OP_QUERY:
            begin
                exec_rsp.slot_id = slot_reg;
                if (slot_in_range)
                begin
                    exec_rsp.found     = slot_alive;
                    exec_rsp.is_alive  = slot_alive;
                    exec_rsp.comp_mask = mask_out(alive_mask);
                    exec_rsp.scene_tag = scene_out(rd_scene);
                end
            end
            default:
            begin
                exec_rsp.found = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        alive_next      = alive_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        taken_next      = taken_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        hold_mask_next  = hold_mask_reg;
        hold_scene_next = hold_scene_reg;
        emit            = 1'b0;
        emit_data       = empty_rsp;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = '0;
        ram_raddr       = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    idx_next        = '0;
                    taken_next      = '0;
                    hold_valid_next = 1'b0;
                    case (op_t'(cmd.operation))
                        OP_CREATE:
                        begin
                            state_next = ST_FREE;
                        end
                        OP_LIST:
                        begin
                            state_next = (limit_in == '0) ? ST_LIST_END : ST_LIST_RD;
                        end
                        default:
                        begin
                            state_next = ST_FETCH;
                        end
                    endcase
                end
            end

            // probe one slot per cycle for the lowest free one
            ST_FREE:
            begin
                if (!alive_reg[idx_reg])
                begin
                    if (can_emit)
                    begin
                        emit                = 1'b1;
                        emit_data           = free_rsp;
                        alive_next[idx_reg] = 1'b1;
                        count_next          = count_inc;
                        ram_we              = 1'b1;
                        ram_waddr           = idx_reg;
                        ram_wdata           = {{COMPONENT_KINDS{1'b0}}, key_reg};
                        state_next          = ST_IDLE;
                    end
                end
                else if (idx_reg == LAST_IDX)
                begin
                    if (can_emit)
                    begin
                        emit       = 1'b1;
                        emit_data  = full_rsp;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            // read the addressed slot
            ST_FETCH:
            begin
                ram_raddr  = slot_idx;
                state_next = ST_EXEC;
            end

            // destroy, attach, query and unknown codes
            ST_EXEC:
            begin
                ram_raddr = slot_idx;
                if (can_emit)
                begin
                    emit       = 1'b1;
                    emit_data  = exec_rsp;
                    state_next = ST_IDLE;
                    if (slot_in_range && (op_reg == OP_DESTROY))
                    begin
                        alive_next[slot_idx] = 1'b0;
                        count_next           = count_dec;
                    end
                    if (slot_in_range && (op_reg == OP_ATTACH) && attach_ok)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = slot_idx;
                        ram_wdata = {attach_mask, rd_scene};
                    end
                end
            end

            // listing: skip dead slots, read live ones
            ST_LIST_RD:
            begin
                if (alive_reg[idx_reg])
                begin
                    state_next = ST_LIST_CHK;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_LIST_END;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            // listing: compare scene, push the previous match out
            ST_LIST_CHK:
            begin
                if (rd_scene == key_reg)
                begin
                    if (!hold_valid_reg || can_emit)
                    begin
                        if (hold_valid_reg)
                        begin
                            emit      = 1'b1;
                            emit_data = hold_rsp;
                        end
                        hold_valid_next = 1'b1;
                        hold_slot_next  = idx_reg;
                        hold_mask_next  = rd_mask;
                        hold_scene_next = rd_scene;
                        taken_next      = taken_inc;
                        if ((taken_inc == limit_reg) || (idx_reg == LAST_IDX))
                        begin
                            state_next = ST_LIST_END;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IW'(1);
                            state_next = ST_LIST_RD;
                        end
                    end
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_LIST_END;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_LIST_RD;
                end
            end

            // listing: final match with last set, or the empty answer
            ST_LIST_END:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (hold_valid_reg)
                    begin
                        emit_data      = hold_rsp;
                        emit_data.last = 1'b1;
                    end
                    else
                    begin
                        emit_data = empty_rsp;
                    end
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // response register
    assign out_valid_next = emit || (out_valid_reg && !rsp.ready);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            alive_reg      <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            taken_reg      <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            alive_reg      <= alive_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            taken_reg      <= taken_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            op_reg    <= cmd.operation;
            slot_reg  <= cmd.slot;
            key_reg   <= key_in;
            comp_reg  <= cmd.component;
            limit_reg <= limit_in;
        end
        hold_slot_reg  <= hold_slot_next;
        hold_mask_reg  <= hold_mask_next;
        hold_scene_reg <= hold_scene_next;
        if (emit)
        begin
            out_reg <= emit_data;
        end
    end

    // response channel
    assign rsp.valid      = out_valid_reg;
    assign rsp.found      = out_reg.found;
    assign rsp.slot_id    = out_reg.slot_id;
    assign rsp.is_alive   = out_reg.is_alive;
    assign rsp.comp_mask  = out_reg.comp_mask;
    assign rsp.scene_tag  = out_reg.scene_tag;
    assign rsp.live_count = out_reg.live_count;
    assign rsp.last       = out_reg.last;

endmodule

FILE: rtl/core/esa_ram.sv
// ----------------------------------------------------------------------------
// esa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module esa_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/esa_checker.sv
// ----------------------------------------------------------------------------
// esa_checker
// port level checks of the slot allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "entity_slot_allocator_defines.svh"

module esa_checker #(
    parameter int SLOTS = 64
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        out_found,
    input logic                        out_is_alive,
    input logic [esa_pkg::MASK_W-1:0]  out_comp_mask,
    input logic [esa_pkg::COUNT_W-1:0] out_live_count,
    input logic                        out_last
);

    // a stalled response stays offered
    `ESA_ASSERT(a_rsp_held, out_valid && !out_ready |=> out_valid, "response dropped while stalled")

    // the sequencer is busy right after it takes a transaction
    `ESA_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready held after accept")

    // only listing matches are ever followed by more responses
    `ESA_ASSERT(a_mid_found, out_valid && !out_last |-> out_found, "non-final response without match")

    // a dead slot never reports a component
    `ESA_ASSERT(a_dead_mask, !out_valid || out_is_alive || (out_comp_mask == '0), "mask on dead slot")

    // live counter stays within the pool
    `ESA_ASSERT(a_count_bound, out_valid |-> (out_live_count <= SLOTS), "live count above pool size")

endmodule

bind entity_slot_allocator esa_checker #(
    .SLOTS (SLOTS)
) u_esa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (cmd.valid),
    .in_ready       (cmd.ready),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_found      (rsp.found),
    .out_is_alive   (rsp.is_alive),
    .out_comp_mask  (rsp.comp_mask),
    .out_live_count (rsp.live_count),
    .out_last       (rsp.last)
);

FILE: tb/entity_slot_allocator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// entity_slot_allocator_checker
// watches the command and response channels of the slot allocator, keeps its
// own copy of the slot pool, and compares every response with the oldest
// expected one. a failure count and the number of responses still due go to
// the testbench top.
// ----------------------------------------------------------------------------
module entity_slot_allocator_checker #(
    parameter int SLOTS           = 64,
    parameter int COMPONENT_KINDS = 7,
    parameter int SCENE_BITS      = 4
) (
    input  logic clk,
    input  logic rst_n,
    esa_cmd_if   cmd,
    esa_rsp_if   rsp,
    output int   errors,
    output int   pending,
    output int   replies_seen
);
    import esa_pkg::*;

    localparam logic [SCENE_W-1:0] SCENE_KEEP = SCENE_W'((1 << SCENE_BITS) - 1);

    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  slot_id;
        logic               is_alive;
        logic [MASK_W-1:0]  comp_mask;
        logic [SCENE_W-1:0] scene_tag;
        logic [COUNT_W-1:0] live_count;
        logic               last;
    } reply_t;

    // shadow of the slot pool
    logic               live      [SLOTS];
    logic [MASK_W-1:0]  comp_bits [SLOTS];
    logic [SCENE_W-1:0] scene_of  [SLOTS];
    logic [COUNT_W-1:0] live_total;

    reply_t replies_due [$];
    int     err_total;
    int     seen_total;
    int     due_total;

    assign errors       = err_total;
    assign pending      = due_total;
    assign replies_seen = seen_total;

    initial
    begin
        err_total  = 0;
        seen_total = 0;
        due_total  = 0;
        live_total = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            live[i]      = 1'b0;
            comp_bits[i] = '0;
            scene_of[i]  = '0;
        end
    end

    // queue one expected response, tagged with the live count after the command
    function automatic void queue_reply(input logic found, input logic [SLOT_W-1:0] id,
                                        input logic alive, input logic [MASK_W-1:0] mask,
                                        input logic [SCENE_W-1:0] tag, input logic last);
        reply_t r;
        r.found      = found;
        r.slot_id    = id;
        r.is_alive   = alive;
        r.comp_mask  = mask;
        r.scene_tag  = tag;
        r.live_count = live_total;
        r.last       = last;
        replies_due.push_back(r);
    endfunction

    // update the pool for one accepted command and queue its responses
    task automatic apply_pool_command(input logic [OP_W-1:0] op,
                                      input logic [SLOT_W-1:0] slot,
                                      input logic [SCENE_W-1:0] scene,
                                      input logic [COMP_W-1:0] comp,
                                      input logic [MAXC_W-1:0] maxc);
        int                 idx;
        int                 cap;
        int                 hits;
        int                 emitted;
        logic               ok;
        logic [SCENE_W-1:0] tag;
        idx = -1;
        tag = scene & SCENE_KEEP;
        case (op)
            OP_CREATE:
            begin
                // lowest dead slot wins
                for (int i = 0; i < SLOTS; i++)
                    if (!live[i] && idx < 0)
                        idx = i;
                if (idx < 0)
                    queue_reply(1'b0, '0, 1'b0, '0, '0, 1'b1);
                else
                begin
                    live[idx]      = 1'b1;
                    comp_bits[idx] = '0;
                    scene_of[idx]  = tag;
                    if (live_total < SLOTS)
                        live_total = live_total + 1'b1;
                    queue_reply(1'b1, SLOT_W'(idx), 1'b1, '0, tag, 1'b1);
                end
            end
            OP_DESTROY:
            begin
                if (int'(slot) >= SLOTS)
                    queue_reply(1'b0, slot, 1'b0, '0, '0, 1'b1);
                else
                begin
                    // the count drops even when the slot was already dead
                    live[slot]      = 1'b0;
                    comp_bits[slot] = '0;
                    if (live_total > 0)
                        live_total = live_total - 1'b1;
                    queue_reply(1'b1, slot, 1'b0, '0, '0, 1'b1);
                end
            end
            OP_ATTACH:
            begin
                if (int'(slot) >= SLOTS)
                    queue_reply(1'b0, slot, 1'b0, '0, '0, 1'b1);
                else
                begin
                    ok = live[slot] && (int'(comp) < COMPONENT_KINDS);
                    if (ok)
                        comp_bits[slot] = comp_bits[slot] | MASK_W'(1 << comp);
                    queue_reply(ok, slot, live[slot], comp_bits[slot], scene_of[slot], 1'b1);
                end
            end
            OP_QUERY:
            begin
                if (int'(slot) >= SLOTS)
                    queue_reply(1'b0, slot, 1'b0, '0, '0, 1'b1);
                else
                    queue_reply(live[slot], slot, live[slot], comp_bits[slot],
                                scene_of[slot], 1'b1);
            end
            OP_LIST:
            begin
                // count the matches first so the final one can carry last
                cap  = (int'(maxc) > SLOTS) ? SLOTS : int'(maxc);
                hits = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (live[i] && scene_of[i] == tag && hits < cap)
                        hits++;
                if (hits == 0)
                    queue_reply(1'b0, '0, 1'b0, '0, '0, 1'b1);
                else
                begin
                    emitted = 0;
                    for (int i = 0; i < SLOTS && emitted < hits; i++)
                        if (live[i] && scene_of[i] == tag)
                        begin
                            emitted++;
                            queue_reply(1'b1, SLOT_W'(i), 1'b1, comp_bits[i], scene_of[i],
                                        emitted == hits);
                        end
                end
            end
            default:
                queue_reply(1'b0, '0, 1'b0, '0, '0, 1'b1);
        endcase
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            err_total++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // compare one response transaction with the oldest expectation
    task automatic check_reply();
        reply_t want;
        seen_total++;
        if (replies_due.size() == 0)
        begin
            err_total++;
            $display("%0t: response with nothing expected, expected none actual slot_id %0d",
                     $time, rsp.slot_id);
        end
        else
        begin
            want = replies_due.pop_front();
            check_field("found",      8'(want.found),      8'(rsp.found));
            check_field("slot_id",    8'(want.slot_id),    8'(rsp.slot_id));
            check_field("is_alive",   8'(want.is_alive),   8'(rsp.is_alive));
            check_field("comp_mask",  8'(want.comp_mask),  8'(rsp.comp_mask));
            check_field("scene_tag",  8'(want.scene_tag),  8'(rsp.scene_tag));
            check_field("live_count", 8'(want.live_count), 8'(rsp.live_count));
            check_field("last",       8'(want.last),       8'(rsp.last));
        end
    endtask

    // responses are checked before the same edge's command is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
                check_reply();
            if (cmd.valid && cmd.ready)
                apply_pool_command(cmd.operation, cmd.slot, cmd.scene, cmd.component,
                                   cmd.max_count);
            due_total = replies_due.size();
        end
    end

endmodule

FILE: tb/entity_slot_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// entity_slot_allocator_tb
// drives create, destroy, attach, query and scene listing commands into the
// slot allocator with random gaps and response stalls, fills the pool past
// full, and leaves checking to the checker module beside the block
// ----------------------------------------------------------------------------
module entity_slot_allocator_tb;
    import esa_pkg::*;

    localparam int SLOTS           = 64;
    localparam int COMPONENT_KINDS = 7;
    localparam int SCENE_BITS      = 4;

    // operation codes the block does not define
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_TAIL  = 150;
    localparam int HOLD_AFTER  = 40;

    logic clk = 1'b0;
    logic rst_n;

    esa_cmd_if cmd_ch();
    esa_rsp_if rsp_ch();

    int err_count;
    int due_count;
    int replies_seen;

    // stimulus-side view of the pool, to keep reads off never-written scene tags
    bit alive_sh   [SLOTS];
    bit written_sh [SLOTS];

    bit burst = 1'b0;
    int items_sent = 0;
    int full_creates = 0;
    int lists_sent = 0;
    int fill_items = 0;
    int cycles = 0;

    always #5 clk = ~clk;

    entity_slot_allocator #(
        .SLOTS           (SLOTS),
        .COMPONENT_KINDS (COMPONENT_KINDS),
        .SCENE_BITS      (SCENE_BITS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    entity_slot_allocator_checker #(
        .SLOTS           (SLOTS),
        .COMPONENT_KINDS (COMPONENT_KINDS),
        .SCENE_BITS      (SCENE_BITS)
    ) chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_ch),
        .rsp          (rsp_ch),
        .errors       (err_count),
        .pending      (due_count),
        .replies_seen (replies_seen)
    );

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses still due", cycles, due_count);
            $display("entity_slot_allocator_tb: errors");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // random slot that is alive, or that has had its scene tag written
    function automatic int pick_slot(input bit from_alive);
        int start;
        int s;
        start = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS; k++)
        begin
            s = (start + k) % SLOTS;
            if (from_alive ? alive_sh[s] : written_sh[s])
                return s;
        end
        return -1;
    endfunction

    // half the scenes crowd into a few tags so listings find several matches
    function automatic int pick_scene();
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 15);
        return $urandom_range(13, 15);
    endfunction

    function automatic int pick_limit();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom_range(0, 4);
        if (r < 8)
            return $urandom_range(5, 64);
        return $urandom_range(65, 127);
    endfunction

    // offer one command transaction and hold it until accepted
    task automatic send_command(input logic [OP_W-1:0] op, input int slot, input int scene,
                                input int comp, input int maxc);
        int gap;
        int free_idx;
        gap = burst ? 0 : idle_cycles();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.operation <= op;
        cmd_ch.slot      <= SLOT_W'(slot);
        cmd_ch.scene     <= SCENE_W'(scene);
        cmd_ch.component <= COMP_W'(comp);
        cmd_ch.max_count <= MAXC_W'(maxc);
        // commands run in order, so the view can move on at once
        if (op == OP_CREATE)
        begin
            free_idx = -1;
            for (int i = 0; i < SLOTS; i++)
                if (!alive_sh[i] && free_idx < 0)
                    free_idx = i;
            if (free_idx < 0)
                full_creates++;
            else
            begin
                alive_sh[free_idx]   = 1'b1;
                written_sh[free_idx] = 1'b1;
            end
        end
        else if (op == OP_DESTROY)
            alive_sh[slot] = 1'b0;
        else if (op == OP_LIST)
            lists_sent++;
        items_sent++;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering until every expected response is back
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (due_count != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // one random command; the percentages weight creates and destroys
    task automatic random_command(input int create_pct, input int destroy_pct);
        int r;
        int s;
        r = $urandom_range(0, 99);
        if (r < create_pct)
            send_command(OP_CREATE, $urandom_range(0, 63), pick_scene(),
                         $urandom_range(0, 7), $urandom_range(0, 127));
        else if (r < create_pct + destroy_pct)
        begin
            s = ($urandom_range(0, 9) < 7) ? pick_slot(1'b1) : -1;
            if (s < 0)
                s = $urandom_range(0, SLOTS - 1);
            send_command(OP_DESTROY, s, $urandom_range(0, 15), $urandom_range(0, 7),
                         $urandom_range(0, 127));
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                s = pick_slot(1'b0);
                if (s < 0)
                    send_command(OP_CREATE, 0, pick_scene(), 0, 0);
                else
                    send_command((r < 40) ? OP_ATTACH : OP_QUERY, s, $urandom_range(0, 15),
                                 $urandom_range(0, 7), $urandom_range(0, 127));
            end
            else if (r < 90)
                send_command(OP_LIST, $urandom_range(0, 63), pick_scene(),
                             $urandom_range(0, 7), pick_limit());
            else
                send_command(OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                             $urandom_range(0, 63), $urandom_range(0, 15),
                             $urandom_range(0, 7), $urandom_range(0, 127));
        end
    endtask

    // response side: random stalls, plus one long hold-off while commands pile up
    initial
    begin
        int g;
        bit held;
        held = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && replies_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clk);
            g = idle_cycles();
            if (g > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (g) @(negedge clk);
            end
        end
    end

    // command side and verdict
    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            alive_sh[i]   = 1'b0;
            written_sh[i] = 1'b0;
        end
        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.operation = '0;
        cmd_ch.slot      = '0;
        cmd_ch.scene     = '0;
        cmd_ch.component = '0;
        cmd_ch.max_count = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: undefined codes, empty pool, destroy at zero count
        send_command(OP_SPARE_FIRST, 63, 15, 7, 127);
        send_command(OP_SPARE_LAST, 0, 0, 0, 0);
        send_command(OP_LIST, 0, 0, 0, 64);
        send_command(OP_DESTROY, 63, 0, 0, 0);
        // first-fit creates in a few scenes
        send_command(OP_CREATE, 0, 15, 0, 0);
        send_command(OP_CREATE, 0, 0, 0, 0);
        send_command(OP_CREATE, 0, 15, 0, 0);
        send_command(OP_CREATE, 0, 5, 0, 0);
        // attach lowest and highest kind, one kind out of range
        send_command(OP_ATTACH, 0, 0, 0, 0);
        send_command(OP_ATTACH, 0, 0, 6, 0);
        send_command(OP_ATTACH, 2, 0, 7, 0);
        send_command(OP_ATTACH, 1, 0, 3, 0);
        send_command(OP_QUERY, 0, 0, 0, 0);
        send_command(OP_QUERY, 3, 0, 0, 0);
        // listing: limit above the pool, limit one, limit zero, no match
        send_command(OP_LIST, 0, 15, 0, 127);
        send_command(OP_LIST, 0, 15, 0, 1);
        send_command(OP_LIST, 0, 15, 0, 0);
        send_command(OP_LIST, 0, 9, 0, 64);
        // destroy twice, then touch the dead slot and reuse it
        send_command(OP_DESTROY, 1, 0, 0, 0);
        send_command(OP_DESTROY, 1, 0, 0, 0);
        send_command(OP_ATTACH, 1, 0, 2, 0);
        send_command(OP_QUERY, 1, 0, 0, 0);
        send_command(OP_CREATE, 0, 9, 0, 0);
        send_command(OP_LIST, 0, 9, 0, 64);
        wait_drained();

        // fill the pool until creates fail, back to back
        burst = 1'b1;
        while (full_creates < 3 && fill_items < 200)
        begin
            random_command(85, 3);
            fill_items++;
        end
        burst = 1'b0;
        wait_drained();

        // mixed traffic on a crowded pool
        repeat (30) random_command(25, 25);
        wait_drained();

        // mostly teardown
        repeat (30) random_command(5, 60);
        wait_drained();

        repeat (DRAIN_TAIL) @(negedge clk);

        $display("run covered %0d commands, %0d listings, %0d creates on a full pool",
                 items_sent, lists_sent, full_creates);
        $display("%0d responses checked, one %0d-cycle response hold-off", replies_seen,
                 HOLD_CYCLES);
        if (err_count == 0 && due_count == 0)
            $display("entity_slot_allocator_tb: clean");
        else
            $display("entity_slot_allocator_tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/esa_pkg.sv
rtl/core/esa_if.sv
rtl/core/esa_ram.sv
rtl/core/entity_slot_allocator.sv
rtl/core/esa_checker.sv
tb/entity_slot_allocator_checker.sv
tb/entity_slot_allocator_tb.sv
